[design/plt_pkg.sv]
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the positional list table
// Operation codes, the entry record, the broadcast command of the cell row and
// the record that each group of cells hands along the scan line.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int GROUP_SIZE   = 8;
    localparam int GROUP_OFF_W  = $clog2(GROUP_SIZE);

    localparam int KEY_W  = 64;
    localparam int PAY_W  = 64;
    localparam int POS_W  = 8;
    localparam int FUNC_W = 3;
    localparam int LEN_W  = 8;

    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 152;

    typedef enum logic [FUNC_W-1:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } func_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

    // broadcast to every cell in the cycle an item is taken
    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic             rd_en;
        logic [POS_W-1:0] pidx;
        entry_t           ent;
    } cmd_t;

    typedef struct packed {
        logic                   any;
        logic [GROUP_OFF_W-1:0] off;
        entry_t                 ent;
    } group_rec_t;

endpackage

[design/plt_cell.sv]
// ----------------------------------------------------------------------------
// plt_cell: one list entry
// Holds one key and payload, shifts up on insert and down on delete, and
// reports a key match and its own value when it is the addressed entry.
// ----------------------------------------------------------------------------
module plt_cell
    import plt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 8
) (
    input  logic             aclk,
    input  cmd_t             cmd,
    input  logic [KEY_W-1:0] search_key,
    input  logic [CNT_W-1:0] count,
    input  entry_t           prev_q,
    input  entry_t           next_q,
    output entry_t           q,
    output logic             match,
    output entry_t           sel_q
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   is_pos;

    assign is_pos = (INDEX == int'(cmd.pidx));

    always_comb begin
        ent_next = ent_reg;
        if (cmd.ins_en) begin
            if (INDEX > int'(cmd.pidx)) begin
                ent_next = prev_q;
            end else if (is_pos) begin
                ent_next = cmd.ent;
            end
        end else if (cmd.del_en) begin
            if (INDEX >= int'(cmd.pidx)) begin
                ent_next = next_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    assign q     = ent_reg;
    assign match = (ent_reg.key == search_key) && (INDEX < int'(count));
    assign sel_q = (cmd.rd_en && is_pos) ? ent_reg : '0;

endmodule

[design/plt_group.sv]
// ----------------------------------------------------------------------------
// plt_group: reduction of one group of cells
// Captures the first key match and the addressed entry of its cells, then
// passes the record toward the scan head one group per cycle.
// ----------------------------------------------------------------------------
module plt_group
    import plt_pkg::*;
(
    input  logic                             aclk,
    input  logic                             load,
    input  logic                             shift,
    input  logic [GROUP_SIZE-1:0]            match,
    input  entry_t [GROUP_SIZE-1:0]          sel_q,
    input  group_rec_t                       row_in,
    output group_rec_t                       row_q
);

    group_rec_t rec;
    group_rec_t row_reg;
    group_rec_t row_next;

    always_comb begin
        rec = '0;
        // highest index first so the lowest match wins
        for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
            if (match[i]) begin
                rec.any = 1'b1;
                rec.off = GROUP_OFF_W'(i);
            end
        end
        for (int i = 0; i < GROUP_SIZE; i++) begin
            rec.ent = rec.ent | sel_q[i];
        end
    end

    always_comb begin
        row_next = row_reg;
        if (load) begin
            row_next = rec;
        end else if (shift) begin
            row_next = row_in;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    assign row_q = row_reg;

endmodule

[design/positional_list_table.sv]
// ----------------------------------------------------------------------------
// positional_list_table: ordered list of keyed entries
// Row of register cells with get, locate, insert, delete and clear.
// ----------------------------------------------------------------------------
// One word on the s_ channel carries one operation; every operation returns
// exactly one word on the m_ channel. Positions are 1-based.
// Entries live in a row of cells. Insert and delete move every later cell by
// one place in the cycle the word is taken. All cells compare their key and
// position at that edge, and groups of GROUP_SIZE cells reduce the answer into
// records that shift toward the scan head one group per cycle.
// Insert, clear and rejected operations pass from idle through the hold state
// to the output register; get, locate and delete first walk the scan state
// along the group records and then pass through hold. The next word is taken
// once hold has handed its result on and the block is back in idle.
// One operation is in flight at a time; s_tready is high only while idle.
// The output register lets the next word be taken while a result waits.
// When the receiver stalls, the finished result holds in the output register
// and a following result waits in the block until the register frees.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module positional_list_table
    import plt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // func[2:0], position[10:3], key[74:11], payload[138:75], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status[0], found_position[8:1], key_out[72:9], payload_out[136:73],
    // length_out[144:137], zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NG    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int NCELL = NG * GROUP_SIZE;
    localparam int GW    = (NG > 1) ? $clog2(NG) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [GW-1:0]       gcnt_reg, gcnt_next;
    logic                locate_reg, locate_next;
    logic                hit_reg, hit_next;
    logic                status_reg, status_next;
    logic [CNT_W-1:0]    found_reg, found_next;
    entry_t              acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [FUNC_W-1:0] in_func;
    logic [POS_W-1:0]  in_pos;
    logic [KEY_W-1:0]  in_key;
    logic [PAY_W-1:0]  in_pay;
    logic              accept;
    logic [15:0]       pos16, cnt16;
    logic              rd_ok, ins_ok;
    cmd_t              cmd;
    logic              grp_load, grp_shift;
    logic              out_free;

    entry_t                  cell_q [NCELL];
    logic [NCELL-1:0]        match_vec;
    entry_t [NCELL-1:0]      sel_vec;
    group_rec_t              row_q  [NG];
    group_rec_t              row_in [NG];

    assign in_func = s_tdata[2:0];
    assign in_pos  = s_tdata[10:3];
    assign in_key  = s_tdata[74:11];
    assign in_pay  = s_tdata[138:75];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign pos16  = 16'(in_pos);
    assign cnt16  = 16'(count_reg);
    assign rd_ok  = (in_pos != '0) && (pos16 <= cnt16);
    assign ins_ok = (in_pos != '0) && (pos16 <= cnt16 + 16'd1)
                    && (cnt16 < 16'(CAPACITY));

    always_comb begin
        cmd        = '0;
        cmd.pidx   = in_pos - POS_W'(1);
        cmd.ent    = '{key: in_key, payload: in_pay};
        cmd.ins_en = accept && (in_func == OP_INSERT) && ins_ok;
        cmd.del_en = accept && (in_func == OP_DELETE) && rd_ok;
        cmd.rd_en  = ((in_func == OP_GET) || (in_func == OP_DELETE)) && rd_ok;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            entry_t prev_q, next_q;
            if (gi == 0) begin : g_first
                assign prev_q = cmd.ent;
            end else begin : g_mid
                assign prev_q = cell_q[gi-1];
            end
            if (gi == NCELL - 1) begin : g_last
                assign next_q = cell_q[gi];
            end else begin : g_inner
                assign next_q = cell_q[gi+1];
            end
            plt_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .search_key (in_key),
                .count      (count_reg),
                .prev_q     (prev_q),
                .next_q     (next_q),
                .q          (cell_q[gi]),
                .match      (match_vec[gi]),
                .sel_q      (sel_vec[gi])
            );
        end

        for (gi = 0; gi < NG; gi++) begin : g_group
            if (gi == NG - 1) begin : g_tail
                assign row_in[gi] = '0;
            end else begin : g_link
                assign row_in[gi] = row_q[gi+1];
            end
            plt_group u_group (
                .aclk   (aclk),
                .load   (grp_load),
                .shift  (grp_shift),
                .match  (match_vec[gi*GROUP_SIZE +: GROUP_SIZE]),
                .sel_q  (sel_vec[gi*GROUP_SIZE +: GROUP_SIZE]),
                .row_in (row_in[gi]),
                .row_q  (row_q[gi])
            );
        end
    endgenerate

    assign grp_load  = accept;
    assign grp_shift = (state_reg == ST_SCAN);
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        gcnt_next    = gcnt_reg;
        locate_next  = locate_reg;
        hit_next     = hit_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    gcnt_next   = '0;
                    hit_next    = 1'b0;
                    found_next  = '0;
                    acc_next    = '0;
                    locate_next = (in_func == OP_LOCATE);
                    state_next  = ST_HOLD;
                    case (in_func)
                        OP_GET: begin
                            status_next = !rd_ok;
                            if (rd_ok) begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_LOCATE: begin
                            status_next = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        OP_INSERT: begin
                            status_next = !ins_ok;
                            if (ins_ok) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            status_next = !rd_ok;
                            if (rd_ok) begin
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            status_next = 1'b0;
                            count_next  = '0;
                        end
                        default: begin
                            status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (locate_reg) begin
                    if (!hit_reg && row_q[0].any) begin
                        hit_next    = 1'b1;
                        status_next = 1'b0;
                        found_next  = CNT_W'({gcnt_reg, row_q[0].off}) + CNT_W'(1);
                    end
                end else begin
                    acc_next = acc_reg | row_q[0].ent;
                end
                gcnt_next = gcnt_reg + GW'(1);
                if (gcnt_reg == GW'(NG - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({LEN_W'(count_reg), acc_reg.payload,
                                              acc_reg.key, LEN_W'(found_reg),
                                              status_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gcnt_reg   <= gcnt_next;
        locate_reg <= locate_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
